FILE: sv/pfr_pkg.sv
`timescale 1ns / 1ps

package pfr_pkg;

    // Width of the objective fields on the ports
    localparam int FIELD_W = 32;
    // Width of the index and rank fields on the ports
    localparam int INDEX_W = 6;
    localparam int RANK_W  = 6;

    // Sequencer states: load words, latch a front, rotate the ring, flush the last word
    typedef enum logic [1:0] {
        S_LOAD,
        S_LATCH,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Per-cycle commands broadcast to every cell of the ring
    typedef struct packed {
        logic load;
        logic latch;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

FILE: sv/pfr_cell.sv
`timescale 1ns / 1ps

module pfr_cell #(
    parameter int MAX_SOLUTIONS   = 64,
    parameter int OBJECTIVE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfr_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_sel,
    input  logic [MAX_SOLUTIONS-1:0]   i_load_bit,
    input  logic [OBJECTIVE_WIDTH-1:0] i_new_obj_one,
    input  logic [OBJECTIVE_WIDTH-1:0] i_new_obj_two,
    input  logic [MAX_SOLUTIONS-1:0]   i_gather,
    input  logic [MAX_SOLUTIONS-1:0]   i_rem,
    input  logic [OBJECTIVE_WIDTH-1:0] i_nb_obj_one,
    input  logic [OBJECTIVE_WIDTH-1:0] i_nb_obj_two,
    input  logic [MAX_SOLUTIONS-1:0]   i_nb_mask,
    input  logic                       i_nb_valid,
    input  logic                       i_nb_emitted,
    input  logic                       i_nb_flag,
    output logic [OBJECTIVE_WIDTH-1:0] o_obj_one,
    output logic [OBJECTIVE_WIDTH-1:0] o_obj_two,
    output logic [MAX_SOLUTIONS-1:0]   o_mask,
    output logic                       o_valid,
    output logic                       o_emitted,
    output logic                       o_flag,
    output logic                       o_dom_new,
    output logic                       o_flag_next
);

    logic [OBJECTIVE_WIDTH-1:0] r_obj_one;
    logic [OBJECTIVE_WIDTH-1:0] r_obj_two;
    logic [MAX_SOLUTIONS-1:0]   r_mask;
    logic                       r_valid;
    logic                       r_emitted;
    logic                       r_flag;
    logic                       n_flag;
    logic                       ge_one, ge_two, gt_one, gt_two;
    logic                       mine_dom_new, new_dom_mine;

    // Compare the held solution with the incoming word
    always_comb begin
        ge_one       = $signed(r_obj_one) >= $signed(i_new_obj_one);
        ge_two       = $signed(r_obj_two) >= $signed(i_new_obj_two);
        gt_one       = $signed(r_obj_one) >  $signed(i_new_obj_one);
        gt_two       = $signed(r_obj_two) >  $signed(i_new_obj_two);
        mine_dom_new = ge_one & ge_two & (gt_one | gt_two);
        new_dom_mine = ~gt_one & ~gt_two & (~ge_one | ~ge_two);
        // In the current front when no remaining solution dominates this one
        n_flag       = r_valid & ~r_emitted & ~|(r_mask & i_rem);
    end

    // Control bits of the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_emitted <= 1'b0;
            r_flag    <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid   <= 1'b0;
            r_emitted <= 1'b0;
            r_flag    <= 1'b0;
        end else if (i_ctl.shift) begin
            // A flagged solution leaves the head during this pass: mark it emitted
            r_valid   <= i_nb_valid;
            r_emitted <= i_nb_emitted | i_nb_flag;
            r_flag    <= i_nb_flag;
        end else if (i_ctl.latch) begin
            r_flag    <= n_flag;
        end else if (i_ctl.load && i_sel) begin
            r_valid   <= 1'b1;
            r_emitted <= 1'b0;
            r_flag    <= 1'b0;
        end
    end

    // Payload of the cell: objectives and dominator mask
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_obj_one <= i_nb_obj_one;
            r_obj_two <= i_nb_obj_two;
            r_mask    <= i_nb_mask;
        end else if (i_ctl.load) begin
            if (i_sel) begin
                r_obj_one <= i_new_obj_one;
                r_obj_two <= i_new_obj_two;
                r_mask    <= i_gather;
            end else if (r_valid && new_dom_mine) begin
                r_mask    <= r_mask | i_load_bit;
            end
        end
    end

    assign o_obj_one   = r_obj_one;
    assign o_obj_two   = r_obj_two;
    assign o_mask      = r_mask;
    assign o_valid     = r_valid;
    assign o_emitted   = r_emitted;
    assign o_flag      = r_flag;
    assign o_dom_new   = r_valid & mine_dom_new;
    assign o_flag_next = n_flag;

endmodule

FILE: sv/pareto_front_ranker_core.sv
`timescale 1ns / 1ps

// Two-objective Pareto front sorter. Solutions load one word per cycle while busy is low
// (start high); each new word is compared at once against every stored cell and the
// dominator masks are updated in that cycle. The word with last_item set closes the set,
// busy rises and the fronts are peeled: for each front the ring latches its members
// (S_LATCH), rotates its MAX_SOLUTIONS cells past the head (S_SCAN) and flushes the
// final word (S_FLUSH). Results come out one word per strobe by ascending load index
// inside each front; the receiver cannot stall them and must take every strobed word.
// Words beyond MAX_SOLUTIONS are dropped and flagged through dropped_any on every
// result of that set.
module pareto_front_ranker_core #(
    parameter int MAX_SOLUTIONS   = 64,
    parameter int OBJECTIVE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pfr_pkg::FIELD_W-1:0]  i_objective_one,
    input  logic signed [pfr_pkg::FIELD_W-1:0]  i_objective_two,
    input  logic                                i_last_item,
    output logic                                o_valid,
    output logic [pfr_pkg::INDEX_W-1:0]         o_solution_index,
    output logic [pfr_pkg::RANK_W-1:0]          o_front_rank,
    output logic signed [pfr_pkg::FIELD_W-1:0]  o_out_objective_one,
    output logic signed [pfr_pkg::FIELD_W-1:0]  o_out_objective_two,
    output logic                                o_front_end,
    output logic                                o_run_end,
    output logic                                o_dropped_any
);

    localparam int IDX_W = $clog2(MAX_SOLUTIONS);
    localparam int CNT_W = $clog2(MAX_SOLUTIONS + 1);
    localparam int OW    = OBJECTIVE_WIDTH;
    localparam int FW    = pfr_pkg::FIELD_W;

    pfr_pkg::t_state    r_state, n_state;
    pfr_pkg::t_cell_ctl w_ctl;

    logic [CNT_W-1:0]             r_count;
    logic                         r_overflow;
    logic [pfr_pkg::RANK_W-1:0]   r_rank;
    logic [IDX_W-1:0]             r_head;
    logic                         r_last_front;
    logic                         r_pend_valid;
    logic [IDX_W-1:0]             r_pend_idx;
    logic [OW-1:0]                r_pend_one;
    logic [OW-1:0]                r_pend_two;
    logic                         r_o_valid;
    logic [pfr_pkg::INDEX_W-1:0]  r_o_index;
    logic [pfr_pkg::RANK_W-1:0]   r_o_rank;
    logic [FW-1:0]                r_o_one;
    logic [FW-1:0]                r_o_two;
    logic                         r_o_front_end;
    logic                         r_o_run_end;
    logic                         r_o_drop;

    logic                         w_accept;
    logic                         w_room;
    logic [OW-1:0]                w_new_one, w_new_two;
    logic [FW-1:0]                w_pend_one_out, w_pend_two_out;
    logic [MAX_SOLUTIONS-1:0]     w_load_bit;
    logic [MAX_SOLUTIONS-1:0]     w_dom_new;
    logic [MAX_SOLUTIONS-1:0]     w_rem;
    logic [MAX_SOLUTIONS-1:0]     w_valid, w_emitted, w_flag, w_flag_next;
    logic [OW-1:0]                w_obj_one [MAX_SOLUTIONS];
    logic [OW-1:0]                w_obj_two [MAX_SOLUTIONS];
    logic [MAX_SOLUTIONS-1:0]     w_mask    [MAX_SOLUTIONS];

    assign busy     = (r_state != pfr_pkg::S_LOAD);
    assign w_accept = start & ~busy;
    assign w_room   = (r_count < CNT_W'(MAX_SOLUTIONS));
    assign w_rem    = w_valid & ~w_emitted;

    // Fit the port objectives to the stored width and back
    generate
        if (OW <= FW) begin : g_narrow
            assign w_new_one      = i_objective_one[OW-1:0];
            assign w_new_two      = i_objective_two[OW-1:0];
            assign w_pend_one_out = FW'(r_pend_one);
            assign w_pend_two_out = FW'(r_pend_two);
        end else begin : g_wide
            assign w_new_one      = {{(OW-FW){i_objective_one[FW-1]}}, i_objective_one};
            assign w_new_two      = {{(OW-FW){i_objective_two[FW-1]}}, i_objective_two};
            assign w_pend_one_out = r_pend_one[FW-1:0];
            assign w_pend_two_out = r_pend_two[FW-1:0];
        end
    endgenerate

    // Ring of cells: cell g takes its neighbor g+1 on a shift, the head wraps to the tail
    generate
        for (genvar g = 0; g < MAX_SOLUTIONS; g++) begin : g_cell
            localparam int NB = (g + 1) % MAX_SOLUTIONS;

            assign w_load_bit[g] = (r_count == CNT_W'(g));

            pfr_cell #(
                .MAX_SOLUTIONS   (MAX_SOLUTIONS),
                .OBJECTIVE_WIDTH (OBJECTIVE_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_sel         (w_load_bit[g]),
                .i_load_bit    (w_load_bit),
                .i_new_obj_one (w_new_one),
                .i_new_obj_two (w_new_two),
                .i_gather      (w_dom_new),
                .i_rem         (w_rem),
                .i_nb_obj_one  (w_obj_one[NB]),
                .i_nb_obj_two  (w_obj_two[NB]),
                .i_nb_mask     (w_mask[NB]),
                .i_nb_valid    (w_valid[NB]),
                .i_nb_emitted  (w_emitted[NB]),
                .i_nb_flag     (w_flag[NB]),
                .o_obj_one     (w_obj_one[g]),
                .o_obj_two     (w_obj_two[g]),
                .o_mask        (w_mask[g]),
                .o_valid       (w_valid[g]),
                .o_emitted     (w_emitted[g]),
                .o_flag        (w_flag[g]),
                .o_dom_new     (w_dom_new[g]),
                .o_flag_next   (w_flag_next[g])
            );
        end
    endgenerate

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfr_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequencer and drive the cell commands
    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        case (r_state)
            pfr_pkg::S_LOAD: begin
                if (w_accept) begin
                    w_ctl.load = w_room;
                    if (i_last_item) begin
                        n_state = pfr_pkg::S_LATCH;
                    end
                end
            end
            pfr_pkg::S_LATCH: begin
                w_ctl.latch = 1'b1;
                n_state     = pfr_pkg::S_SCAN;
            end
            pfr_pkg::S_SCAN: begin
                w_ctl.shift = 1'b1;
                if (r_head == IDX_W'(MAX_SOLUTIONS - 1)) begin
                    n_state = pfr_pkg::S_FLUSH;
                end
            end
            pfr_pkg::S_FLUSH: begin
                if (r_last_front) begin
                    w_ctl.clear = 1'b1;
                    n_state     = pfr_pkg::S_LOAD;
                end else begin
                    n_state = pfr_pkg::S_LATCH;
                end
            end
            default: begin
                n_state = pfr_pkg::S_LOAD;
            end
        endcase
    end

    // Count loads, track fronts and the head position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_rank       <= '0;
            r_head       <= '0;
            r_last_front <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                pfr_pkg::S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= CNT_W'(r_count + 1'b1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                    end
                end
                pfr_pkg::S_LATCH: begin
                    r_head       <= '0;
                    r_pend_valid <= 1'b0;
                    r_last_front <= ~|(w_rem & ~w_flag_next);
                end
                pfr_pkg::S_SCAN: begin
                    r_head <= IDX_W'(r_head + 1'b1);
                    if (w_flag[0]) begin
                        r_pend_valid <= 1'b1;
                    end
                end
                pfr_pkg::S_FLUSH: begin
                    if (r_last_front) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_rank     <= '0;
                    end else begin
                        r_rank <= pfr_pkg::RANK_W'(r_rank + 1'b1);
                    end
                end
                default: begin
                    r_head <= '0;
                end
            endcase
        end
    end

    // Hold the last front member seen at the head until the next one shows
    always_ff @(posedge i_clk) begin
        if (r_state == pfr_pkg::S_SCAN && w_flag[0]) begin
            r_pend_idx <= r_head;
            r_pend_one <= w_obj_one[0];
            r_pend_two <= w_obj_two[0];
        end
    end

    // Strobe for one cycle per result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= ((r_state == pfr_pkg::S_SCAN) && w_flag[0] && r_pend_valid)
                       || (r_state == pfr_pkg::S_FLUSH);
        end
    end

    // Result word payload
    always_ff @(posedge i_clk) begin
        if (((r_state == pfr_pkg::S_SCAN) && w_flag[0] && r_pend_valid)
            || (r_state == pfr_pkg::S_FLUSH)) begin
            r_o_index     <= pfr_pkg::INDEX_W'(r_pend_idx);
            r_o_rank      <= r_rank;
            r_o_one       <= w_pend_one_out;
            r_o_two       <= w_pend_two_out;
            r_o_front_end <= (r_state == pfr_pkg::S_FLUSH);
            r_o_run_end   <= (r_state == pfr_pkg::S_FLUSH) && r_last_front;
            r_o_drop      <= r_overflow;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_solution_index    = r_o_index;
    assign o_front_rank        = r_o_rank;
    assign o_out_objective_one = r_o_one;
    assign o_out_objective_two = r_o_two;
    assign o_front_end         = r_o_front_end;
    assign o_run_end           = r_o_run_end;
    assign o_dropped_any       = r_o_drop;

    // A front always has at least one member by the time it is flushed
    a_front_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfr_pkg::S_FLUSH) |-> r_pend_valid)
        else $error("front flushed with no pending member");

    // Sorting only starts with at least one stored solution
    a_latch_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfr_pkg::S_LATCH) |-> (r_count != '0))
        else $error("front latch with empty store");

    // The end of the run closes a front and returns the block to loading
    a_run_end_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end) |-> (o_front_end && !busy))
        else $error("run end without front end or while still busy");

    // Cleared store after the run: nothing left valid
    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end) |-> (w_valid == '0 && r_count == '0))
        else $error("store not cleared at run end");

endmodule

FILE: dv/pareto_front_ranker_core_tb.sv
`timescale 1ns / 1ps

module pareto_front_ranker_core_tb;

    localparam int MAX_SOL     = 64;
    localparam int FIELD_W     = pfr_pkg::FIELD_W;
    localparam int INDEX_W     = pfr_pkg::INDEX_W;
    localparam int RANK_W      = pfr_pkg::RANK_W;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * (MAX_SOL + 2);
    localparam int WORD_TARGET = 320;

    typedef logic signed [FIELD_W-1:0] t_obj;

    localparam t_obj OBJ_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
    localparam t_obj OBJ_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

    // One load word; drain makes the sender wait until all ranked words are out
    typedef struct packed {
        logic signed [FIELD_W-1:0] one;
        logic signed [FIELD_W-1:0] two;
        logic                      last;
        logic                      drain;
    } t_load_word;

    // One expected ranked word; front_id tells fronts apart across runs
    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic [RANK_W-1:0]         rank;
        logic signed [FIELD_W-1:0] one;
        logic signed [FIELD_W-1:0] two;
        logic [31:0]               front_id;
        logic                      last_front;
        logic                      dropped;
    } t_ranked_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    t_obj                      i_objective_one = '0;
    t_obj                      i_objective_two = '0;
    logic                      i_last_item = 1'b0;
    logic                      o_valid;
    logic [INDEX_W-1:0]        o_solution_index;
    logic [RANK_W-1:0]         o_front_rank;
    t_obj                      o_out_objective_one;
    t_obj                      o_out_objective_two;
    logic                      o_front_end;
    logic                      o_run_end;
    logic                      o_dropped_any;

    pareto_front_ranker_core #(
        .MAX_SOLUTIONS   (MAX_SOL),
        .OBJECTIVE_WIDTH (FIELD_W)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_objective_one     (i_objective_one),
        .i_objective_two     (i_objective_two),
        .i_last_item         (i_last_item),
        .o_valid             (o_valid),
        .o_solution_index    (o_solution_index),
        .o_front_rank        (o_front_rank),
        .o_out_objective_one (o_out_objective_one),
        .o_out_objective_two (o_out_objective_two),
        .o_front_end         (o_front_end),
        .o_run_end           (o_run_end),
        .o_dropped_any       (o_dropped_any)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_load_word   load_words[$];
    t_ranked_word ranked_queue[$];

    // Shadow of the ranker state
    t_obj               held_one  [MAX_SOL];
    t_obj               held_two  [MAX_SOL];
    logic [MAX_SOL-1:0] beaten_by [MAX_SOL];
    int                 held_count   = 0;
    bit                 dropped_seen = 1'b0;
    int                 front_serial = 0;

    int words_total = 0;
    int words_taken = 0;
    int mismatches  = 0;
    int stall_cycles = 0;

    // A beats B when no worse on both objectives and strictly better on one
    function automatic bit dominates(t_obj a1, t_obj a2, t_obj b1, t_obj b2);
        return (a1 >= b1) && (a2 >= b2) && ((a1 > b1) || (a2 > b2));
    endfunction

    // Store one word, update dominator masks, and peel fronts on the last word
    task automatic rank_on_load(input t_load_word w);
        logic [MAX_SOL-1:0] left;
        logic [MAX_SOL-1:0] members;
        int                 n;
        int                 i;
        int                 rank;
        t_ranked_word       r;
        if (held_count < MAX_SOL) begin
            n = held_count;
            held_one[n]  = w.one;
            held_two[n]  = w.two;
            beaten_by[n] = '0;
            for (i = 0; i < n; i++) begin
                if (dominates(held_one[i], held_two[i], w.one, w.two))
                    beaten_by[n][i] = 1'b1;
                else if (dominates(w.one, w.two, held_one[i], held_two[i]))
                    beaten_by[i][n] = 1'b1;
            end
            held_count = n + 1;
        end else begin
            dropped_seen = 1'b1;
        end
        if (w.last) begin
            left = '0;
            for (i = 0; i < held_count; i++)
                left[i] = 1'b1;
            rank = 0;
            while (left != '0 && rank < MAX_SOL) begin
                // collect everything no remaining solution beats
                members = '0;
                for (i = 0; i < held_count; i++) begin
                    if (left[i] && (beaten_by[i] & left) == '0)
                        members[i] = 1'b1;
                end
                for (i = 0; i < held_count; i++) begin
                    if (members[i]) begin
                        r.index      = INDEX_W'(i);
                        r.rank       = RANK_W'(rank);
                        r.one        = held_one[i];
                        r.two        = held_two[i];
                        r.front_id   = 32'(front_serial);
                        r.last_front = ((left & ~members) == '0);
                        r.dropped    = dropped_seen;
                        ranked_queue.insert(ranked_queue.size(), r);
                    end
                end
                left = left & ~members;
                rank++;
                front_serial++;
            end
            held_count   = 0;
            dropped_seen = 1'b0;
        end
    endtask

    task automatic add_word(input t_obj one, input t_obj two, input bit last, input bit drain);
        t_load_word w;
        w.one   = one;
        w.two   = two;
        w.last  = last;
        w.drain = drain;
        load_words.insert(load_words.size(), w);
        words_total++;
    endtask

    // Mostly small values so dominance and ties are frequent
    function automatic t_obj pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return t_obj'(int'($urandom_range(0, 6)) - 3);
        else if (roll < 8)
            return t_obj'((int'($urandom_range(0, 6)) - 3) <<< 16);
        else if (roll < 9)
            return t_obj'($urandom);
        case ($urandom_range(0, 3))
            0:       return OBJ_MAX;
            1:       return OBJ_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic add_random_set(input int size, input bit drain);
        int k;
        for (k = 0; k < size; k++)
            add_word(pick_value(), pick_value(), k == size - 1, drain && k == 0);
    endtask

    // Driver: bursts of words from the pending queue with random gaps
    int         burst_left = 1;
    int         gap_left   = 0;
    t_load_word on_bus;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            // take the accepted word into the prediction
            if (start && !busy) begin
                rank_on_load(on_bus);
                words_taken++;
            end
            // hold the word while busy, otherwise advance
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (load_words.size() == 0) begin
                    start <= 1'b0;
                end else if (load_words[0].drain && ranked_queue.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    on_bus = load_words.pop_front();
                    i_objective_one <= on_bus.one;
                    i_objective_two <= on_bus.two;
                    i_last_item     <= on_bus.last;
                    start           <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(4, 16);
                        else
                            gap_left = $urandom_range(0, 2);
                    end
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // Monitor: match each strobed word against the oldest pending front as a set
    int           head_id;
    int           span;
    int           hit;
    int           k;
    t_ranked_word want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (ranked_queue.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual index %0d rank %0d",
                         $time, o_solution_index, o_front_rank);
                mismatches++;
            end else begin
                head_id = ranked_queue[0].front_id;
                span    = 0;
                hit     = -1;
                for (k = 0; k < ranked_queue.size(); k++) begin
                    if (ranked_queue[k].front_id == head_id) begin
                        span++;
                        if (hit < 0 && ranked_queue[k].index == o_solution_index)
                            hit = k;
                    end
                end
                // no member with that index: compare against the head to report it
                if (hit < 0)
                    hit = 0;
                want = ranked_queue[hit];
                check_field("solution_index", want.index, o_solution_index);
                check_field("front_rank", want.rank, o_front_rank);
                check_field("out_objective_one", want.one, o_out_objective_one);
                check_field("out_objective_two", want.two, o_out_objective_two);
                check_field("front_end", span == 1, o_front_end);
                check_field("run_end", span == 1 && want.last_front, o_run_end);
                check_field("dropped_any", want.dropped, o_dropped_any);
                ranked_queue.delete(hit);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    int i;

    initial begin
        // single solution at the extremes
        add_word(OBJ_MAX, OBJ_MIN, 1'b1, 1'b0);
        // corners and zero
        add_word(OBJ_MIN, OBJ_MIN, 1'b0, 1'b0);
        add_word(OBJ_MAX, OBJ_MAX, 1'b0, 1'b0);
        add_word('0, '0, 1'b1, 1'b0);
        // equal solutions share a front
        add_word(t_obj'(5), t_obj'(5), 1'b0, 1'b0);
        add_word(t_obj'(5), t_obj'(5), 1'b0, 1'b0);
        add_word(t_obj'(5), t_obj'(5), 1'b1, 1'b0);
        // trade-off front over dominated points, after a drain
        add_word(t_obj'(1), t_obj'(3), 1'b0, 1'b1);
        add_word(t_obj'(2), t_obj'(2), 1'b0, 1'b0);
        add_word(t_obj'(3), t_obj'(1), 1'b0, 1'b0);
        add_word(t_obj'(0), t_obj'(0), 1'b0, 1'b0);
        add_word(t_obj'(2), t_obj'(1), 1'b1, 1'b0);
        // chain loaded worst first, across the sign boundary
        add_word(OBJ_MIN, OBJ_MIN, 1'b0, 1'b0);
        add_word('1, '1, 1'b0, 1'b0);
        add_word('0, '0, 1'b0, 1'b0);
        add_word(OBJ_MAX, OBJ_MAX, 1'b1, 1'b0);
        // tie on one objective, strictly better on the other
        add_word(t_obj'(4), t_obj'(7), 1'b0, 1'b0);
        add_word(t_obj'(4), t_obj'(9), 1'b0, 1'b0);
        add_word(t_obj'(6), t_obj'(7), 1'b1, 1'b0);

        for (i = 0; i < 10; i++)
            add_random_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);

        // full chain of 64 fronts, then two dropped words, the last one closing
        for (i = 0; i < MAX_SOL; i++)
            add_word(t_obj'((MAX_SOL - i) <<< 16), t_obj'(-3 * i - int'($urandom_range(0, 2))),
                     1'b0, i == 0);
        add_word(t_obj'($urandom), t_obj'($urandom), 1'b0, 1'b0);
        add_word(t_obj'($urandom), t_obj'($urandom), 1'b1, 1'b0);

        // full random set closed by a dropped word
        for (i = 0; i < MAX_SOL; i++)
            add_word(pick_value(), pick_value(), 1'b0, i == 0);
        add_word(pick_value(), pick_value(), 1'b1, 1'b0);

        // exactly full, no overflow
        add_random_set(MAX_SOL, 1'b1);

        while (words_total < WORD_TARGET)
            add_random_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);

        // reset once at the start
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all words in, all ranked words out, then the tail
        @(posedge i_clk);
        while (words_taken != words_total)
            @(posedge i_clk);
        while (ranked_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/pfr_pkg.sv
sv/pfr_cell.sv
sv/pareto_front_ranker_core.sv
dv/pareto_front_ranker_core_tb.sv
